/* src/cfsr_pkg.sv */
package cfsr_pkg;

  localparam logic [7:0]  START_BYTE_RESET = 8'hE7;
  localparam logic [15:0] CRC_POLY         = 16'h1021;
  localparam logic [7:0]  VERSION_MASK     = 8'h07;
  localparam int          FLAG_BIT         = 7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       in_frame;
    logic [8:0] position;
    logic       frame_end;
    logic       crc_ok;
    logic [7:0] msg_type;
    logic [7:0] seq_num;
    logic [2:0] version;
    logic       flag_high;
  } result_t;

  // CRC-16 update by one byte, MSB first, no reflection.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* src/cfsr_byte_if.sv */
interface cfsr_byte_if;
  import cfsr_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

/* src/cfsr_result_if.sv */
interface cfsr_result_if;
  import cfsr_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       in_frame;
  logic [8:0] position;
  logic       frame_end;
  logic       crc_ok;
  logic [7:0] msg_type;
  logic [7:0] seq_num;
  logic [2:0] version;
  logic       flag_high;

  modport source (
    output valid, output data_byte, output in_frame, output position, output frame_end,
    output crc_ok, output msg_type, output seq_num, output version, output flag_high,
    input ready
  );
  modport sink (
    input valid, input data_byte, input in_frame, input position, input frame_end,
    input crc_ok, input msg_type, input seq_num, input version, input flag_high,
    output ready
  );
endinterface

/* src/crc_framed_serial_receiver.sv */
// Channel   Dir  Payload                                         Accepted when
// bytes     in   rx_byte[7:0]                                    valid && ready
// results   out  data_byte, in_frame, position, frame_end,       valid && ready
//                crc_ok, msg_type, seq_num, version, flag_high
// start_byte_we/start_byte_wdata: start byte register, written when we is high.
//
// One item per cycle while the skid entry is empty: each byte is parsed and its CRC
// updated by byte-wide logic in the cycle it is accepted, and its result is registered.
// An output register plus one skid entry decouple the sides; bytes are taken
// whenever the skid entry is empty, so a result stall holds the input only once
// both entries are full.
// Synchronous reset clears the parser to hunting, empties the buffer and sets
// the start byte to 0xE7.
module crc_framed_serial_receiver (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start_byte_we,
  input  logic [7:0]           start_byte_wdata,
  cfsr_byte_if.sink            bytes,
  cfsr_result_if.source        results
);
  import cfsr_pkg::*;

  logic [7:0]  start_byte;
  logic [8:0]  byte_index;
  logic [8:0]  byte_index_next;
  logic [7:0]  frame_length;
  logic [7:0]  frame_length_next;
  logic [15:0] running_crc;
  logic [15:0] running_crc_next;
  logic [7:0]  previous_byte;
  logic [7:0]  previous_byte_next;
  logic [7:0]  version_byte;
  logic [7:0]  version_byte_next;
  logic [7:0]  type_byte;
  logic [7:0]  type_byte_next;
  logic [7:0]  sequence_byte;
  logic [7:0]  sequence_byte_next;

  logic [7:0]  b;
  logic        accept;
  logic        buf_ready;
  logic        is_end;
  logic [15:0] rx_crc;
  result_t     res;
  result_t     out_res;

  assign b      = bytes.rx_byte;
  assign accept = bytes.valid && buf_ready;
  assign bytes.ready = buf_ready;

  always_comb begin
    byte_index_next    = byte_index;
    frame_length_next  = frame_length;
    running_crc_next   = running_crc;
    previous_byte_next = previous_byte;
    version_byte_next  = version_byte;
    type_byte_next     = type_byte;
    sequence_byte_next = sequence_byte;
    res                = '0;
    res.data_byte      = b;
    is_end             = 1'b0;
    rx_crc             = '0;

    if (byte_index == 9'd0) begin
      if (b == start_byte) begin
        previous_byte_next = b;
        running_crc_next   = crc16_byte(16'h0000, b);
        byte_index_next    = 9'd1;
        res.in_frame       = 1'b1;
      end
    end else begin
      res.in_frame = 1'b1;
      res.position = byte_index;
      if (byte_index == 9'd1) begin
        frame_length_next = b;
        if (b == 8'd0) begin
          running_crc_next = 16'h0000;
        end else begin
          if (b >= 8'd2) begin
            running_crc_next = crc16_byte(running_crc, b);
          end
          previous_byte_next = b;
        end
        byte_index_next = 9'd2;
      end else begin
        if (byte_index == 9'd2) begin
          version_byte_next = b;
        end
        if (byte_index == 9'd3) begin
          type_byte_next = b;
        end
        if (byte_index == 9'd4) begin
          sequence_byte_next = b;
        end
        is_end = ({1'b0, byte_index} >= ({2'b00, frame_length} + 10'd1));
        if (frame_length == 8'd0) begin
          rx_crc = {previous_byte, 8'h00};
        end else begin
          rx_crc = {previous_byte, b};
        end
        if (is_end) begin
          res.frame_end   = 1'b1;
          res.crc_ok      = (running_crc == rx_crc);
          res.msg_type    = type_byte_next;
          res.seq_num     = sequence_byte_next;
          res.version     = 3'(version_byte_next & VERSION_MASK);
          res.flag_high   = version_byte_next[FLAG_BIT];
          byte_index_next = 9'd0;
        end else begin
          if ({1'b0, byte_index} < {2'b00, frame_length}) begin
            running_crc_next = crc16_byte(running_crc, b);
          end
          previous_byte_next = b;
          byte_index_next    = byte_index + 9'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte    <= START_BYTE_RESET;
      byte_index    <= '0;
      frame_length  <= '0;
      running_crc   <= '0;
      previous_byte <= '0;
      version_byte  <= '0;
      type_byte     <= '0;
      sequence_byte <= '0;
    end else begin
      if (start_byte_we) begin
        start_byte <= start_byte_wdata;
      end
      if (accept) begin
        byte_index    <= byte_index_next;
        frame_length  <= frame_length_next;
        running_crc   <= running_crc_next;
        previous_byte <= previous_byte_next;
        version_byte  <= version_byte_next;
        type_byte     <= type_byte_next;
        sequence_byte <= sequence_byte_next;
      end
    end
  end

  cfsr_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (bytes.valid),
    .push_ready (buf_ready),
    .push_data  (res),
    .pop_valid  (results.valid),
    .pop_ready  (results.ready),
    .pop_data   (out_res)
  );

  assign results.data_byte = out_res.data_byte;
  assign results.in_frame  = out_res.in_frame;
  assign results.position  = out_res.position;
  assign results.frame_end = out_res.frame_end;
  assign results.crc_ok    = out_res.crc_ok;
  assign results.msg_type  = out_res.msg_type;
  assign results.seq_num   = out_res.seq_num;
  assign results.version   = out_res.version;
  assign results.flag_high = out_res.flag_high;

endmodule

/* src/cfsr_out_buf.sv */
module cfsr_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  cfsr_pkg::result_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output cfsr_pkg::result_t pop_data
);
  import cfsr_pkg::*;

  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;
  logic    push;
  logic    pop;

  assign push_ready = !skid_valid;
  assign push       = push_valid && push_ready;
  assign pop        = out_valid && pop_ready;
  assign pop_valid  = out_valid;
  assign pop_data   = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* dv/tb_crc_framed_serial_receiver.sv */
`timescale 1ns / 100ps

module tb_crc_framed_serial_receiver;
  import cfsr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int N_DIRECTED     = 25;
  localparam int N_PHASES       = 4;
  localparam int PHASE_BYTES    = 160;

  typedef enum logic [1:0] {
    STIM_BYTE,
    STIM_CRC_HI,
    STIM_CRC_LO,
    STIM_CRC_LO_BAD
  } stim_kind_t;

  typedef struct {
    stim_kind_t kind;
    logic [7:0] value;
    bit         typed;
    result_t    golden;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start_byte_we = 1'b0;
  logic [7:0] start_byte_wdata = 8'h00;

  cfsr_byte_if   byte_ch ();
  cfsr_result_if res_ch ();

  crc_framed_serial_receiver DUT (
    .clk              (clk),
    .rst              (rst),
    .start_byte_we    (start_byte_we),
    .start_byte_wdata (start_byte_wdata),
    .bytes            (byte_ch),
    .results          (res_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Frame parser state as the block should hold it.
  logic [7:0]  sof_byte = START_BYTE_RESET;
  logic [8:0]  fr_pos = '0;
  logic [7:0]  fr_len = '0;
  logic [15:0] fr_crc = '0;
  logic [7:0]  fr_last = '0;
  logic [7:0]  fr_hdr_ver = '0;
  logic [7:0]  fr_hdr_type = '0;
  logic [7:0]  fr_hdr_seq = '0;

  result_t expected_results [$];

  int n_errors = 0;
  int n_bytes = 0;
  int n_frames = 0;
  int n_crc_pass = 0;
  int n_sof_writes = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[15] ^ d[i];
      crc = {crc[14:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  function automatic result_t parse_byte(input logic [7:0] b);
    result_t r;
    logic [15:0] rx_crc;
    r = '0;
    r.data_byte = b;
    if (fr_pos == 9'd0) begin
      if (b == sof_byte) begin
        fr_last    = b;
        fr_crc     = crc_step(16'h0000, b);
        fr_pos     = 9'd1;
        r.in_frame = 1'b1;
      end
      return r;
    end
    r.in_frame = 1'b1;
    r.position = fr_pos;
    if (fr_pos == 9'd1) begin
      fr_len = b;
      if (b == 8'd0) begin
        fr_crc = '0;
      end else begin
        if (b >= 8'd2) begin
          fr_crc = crc_step(fr_crc, b);
        end
        fr_last = b;
      end
      fr_pos = 9'd2;
      return r;
    end
    case (fr_pos)
      9'd2: fr_hdr_ver = b;
      9'd3: fr_hdr_type = b;
      9'd4: fr_hdr_seq = b;
      default: ;
    endcase
    if (int'(fr_pos) >= int'(fr_len) + 1) begin
      rx_crc      = (fr_len == 8'd0) ? {fr_last, 8'h00} : {fr_last, b};
      r.frame_end = 1'b1;
      r.crc_ok    = (fr_crc == rx_crc);
      r.msg_type  = fr_hdr_type;
      r.seq_num   = fr_hdr_seq;
      r.version   = 3'(fr_hdr_ver & VERSION_MASK);
      r.flag_high = fr_hdr_ver[FLAG_BIT];
      fr_pos      = 9'd0;
      return r;
    end
    if (int'(fr_pos) < int'(fr_len)) begin
      fr_crc = crc_step(fr_crc, b);
    end
    fr_last = b;
    fr_pos  = fr_pos + 9'd1;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    n_errors++;
  endtask

  // Offers one item, waits for it to be taken, and records what it must produce.
  task automatic send_byte(input logic [7:0] b, input bit use_golden = 1'b0,
                           input result_t golden = '0);
    result_t predicted;
    if ($urandom_range(99) < snd_idle_pct) begin
      byte_ch.valid   <= 1'b0;
      byte_ch.rx_byte <= 8'($urandom);
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    predicted = parse_byte(b);
    expected_results.push_back(use_golden ? golden : predicted);
    n_bytes++;
  endtask

  task automatic drain;
    byte_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_sof(input logic [7:0] v);
    drain();
    start_byte_we    <= 1'b1;
    start_byte_wdata <= v;
    @(posedge clk);
    sof_byte = v;
    n_sof_writes++;
    start_byte_we <= 1'b0;
  endtask

  // A cut of -1 lets the frame run to its end; otherwise at most cut bytes follow the length byte.
  task automatic send_frame(input int len, input bit corrupt, input int cut);
    logic [7:0] b;
    while (fr_pos != 9'd0) send_byte(8'($urandom));
    send_byte(sof_byte);
    send_byte(8'(len));
    while (fr_pos != 9'd0 && cut != 0) begin
      if (fr_len >= 8'd2 && int'(fr_pos) == int'(fr_len)) begin
        b = fr_crc[15:8];
      end else if (int'(fr_pos) == int'(fr_len) + 1) begin
        b = fr_crc[7:0] ^ (corrupt ? 8'($urandom_range(1, 255)) : 8'h00);
      end else begin
        b = 8'($urandom);
      end
      send_byte(b);
      cut--;
    end
  endtask

  task automatic run_traffic(input int n_target);
    int stop_at;
    int sel;
    int len;
    stop_at = n_bytes + n_target;
    while (n_bytes < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 10) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else begin
        sel = $urandom_range(99);
        if (sel < 70) begin
          len = $urandom_range(0, 12);
        end else if (sel < 96) begin
          len = $urandom_range(13, 40);
        end else if (sel < 97) begin
          len = 255;
        end else begin
          len = $urandom_range(0, 255);
        end
        send_frame(len, $urandom_range(9) == 0,
                   ($urandom_range(19) == 0) ? $urandom_range(0, len) : -1);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = '{res_ch.data_byte, res_ch.in_frame, res_ch.position, res_ch.frame_end,
              res_ch.crc_ok, res_ch.msg_type, res_ch.seq_num, res_ch.version,
              res_ch.flag_high};
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected item, data_byte", got.data_byte, 0);
      end else begin
        want = expected_results.pop_front();
        if (got.data_byte !== want.data_byte)
          note_mismatch("data_byte", got.data_byte, want.data_byte);
        if (got.in_frame !== want.in_frame)
          note_mismatch("in_frame", got.in_frame, want.in_frame);
        if (got.position !== want.position)
          note_mismatch("position", got.position, want.position);
        if (got.frame_end !== want.frame_end)
          note_mismatch("frame_end", got.frame_end, want.frame_end);
        if (got.crc_ok !== want.crc_ok)
          note_mismatch("crc_ok", got.crc_ok, want.crc_ok);
        if (got.msg_type !== want.msg_type)
          note_mismatch("msg_type", got.msg_type, want.msg_type);
        if (got.seq_num !== want.seq_num)
          note_mismatch("seq_num", got.seq_num, want.seq_num);
        if (got.version !== want.version)
          note_mismatch("version", got.version, want.version);
        if (got.flag_high !== want.flag_high)
          note_mismatch("flag_high", got.flag_high, want.flag_high);
        if (want.frame_end) begin
          n_frames++;
          if (want.crc_ok) n_crc_pass++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle_cycles = 0;
      end else if (expected_results.size() != 0 || byte_ch.valid) begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d cycles without progress.", idle_cycles);
        $display("crc_framed_serial_receiver regression: fail");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t  dir_rows [N_DIRECTED];
    logic [7:0] phase_sof [N_PHASES];
    int         phase_snd [N_PHASES];
    int         phase_rcv [N_PHASES];
    logic [7:0] b;

    dir_rows = '{
      '{STIM_BYTE, 8'h00, 1'b1, '{8'h00, 1'b0, 9'd0, 1'b0, 1'b0, 8'h00, 8'h00, 3'd0, 1'b0}},
      '{STIM_BYTE, 8'hFF, 1'b1, '{8'hFF, 1'b0, 9'd0, 1'b0, 1'b0, 8'h00, 8'h00, 3'd0, 1'b0}},
      '{STIM_BYTE, 8'hE7, 1'b1, '{8'hE7, 1'b1, 9'd0, 1'b0, 1'b0, 8'h00, 8'h00, 3'd0, 1'b0}},
      '{STIM_BYTE, 8'h00, 1'b1, '{8'h00, 1'b1, 9'd1, 1'b0, 1'b0, 8'h00, 8'h00, 3'd0, 1'b0}},
      '{STIM_BYTE, 8'hFF, 1'b1, '{8'hFF, 1'b1, 9'd2, 1'b1, 1'b0, 8'h00, 8'h00, 3'd7, 1'b1}},
      '{STIM_BYTE, 8'hE7, 1'b0, '0},
      '{STIM_BYTE, 8'h05, 1'b0, '0},
      '{STIM_BYTE, 8'h83, 1'b0, '0},
      '{STIM_BYTE, 8'h3C, 1'b0, '0},
      '{STIM_BYTE, 8'h5A, 1'b0, '0},
      '{STIM_CRC_HI, 8'h00, 1'b0, '0},
      '{STIM_CRC_LO, 8'h00, 1'b0, '0},
      '{STIM_BYTE, 8'hE7, 1'b0, '0},
      '{STIM_BYTE, 8'h03, 1'b0, '0},
      '{STIM_BYTE, 8'h04, 1'b0, '0},
      '{STIM_CRC_HI, 8'h00, 1'b0, '0},
      '{STIM_CRC_LO_BAD, 8'h00, 1'b0, '0},
      '{STIM_BYTE, 8'hE7, 1'b0, '0},
      '{STIM_BYTE, 8'h02, 1'b0, '0},
      '{STIM_CRC_HI, 8'h00, 1'b0, '0},
      '{STIM_CRC_LO, 8'h00, 1'b0, '0},
      '{STIM_BYTE, 8'hE7, 1'b0, '0},
      '{STIM_BYTE, 8'h01, 1'b0, '0},
      '{STIM_CRC_LO, 8'h00, 1'b0, '0},
      '{STIM_BYTE, 8'h7F, 1'b0, '0}
    };
    phase_sof = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)), START_BYTE_RESET};
    phase_snd = '{28, 66, 0, 0};
    phase_rcv = '{66, 28, 0, 0};

    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = 8'h00;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    snd_idle_pct = 28;
    rcv_idle_pct = 66;
    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        STIM_CRC_HI:     b = fr_crc[15:8];
        STIM_CRC_LO:     b = fr_crc[7:0];
        STIM_CRC_LO_BAD: b = fr_crc[7:0] ^ 8'h01;
        default:         b = dir_rows[i].value;
      endcase
      send_byte(b, dir_rows[i].typed, dir_rows[i].golden);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      write_sof(phase_sof[p]);
      snd_idle_pct = phase_snd[p];
      rcv_idle_pct = phase_rcv[p];
      if (phase_snd[p] == 0) begin
        // Stall the result side while a full-length frame streams in.
        hold_req++;
        send_frame(255, 1'b0, -1);
      end
      run_traffic(PHASE_BYTES);
    end

    drain();
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      note_mismatch("results never delivered, count", 0, expected_results.size());
    end

    $display("Sent %0d bytes; %0d frames closed, %0d with a matching CRC.",
             n_bytes, n_frames, n_crc_pass);
    $display("Start byte rewritten %0d times, with idle mixes on both sides and a long stall.",
             n_sof_writes);
    if (n_errors == 0) begin
      $display("crc_framed_serial_receiver regression: pass");
    end else begin
      $display("crc_framed_serial_receiver regression: fail");
    end
    $finish;
  end

endmodule
